// ===== design/tsos_pkg.sv =====
package tsos_pkg;

	// Capacity of the set.
	localparam int ENTRIES = 16;
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	// Operation codes.
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	// Result status codes.
	localparam logic [2:0] STS_ADDED     = 3'd0;
	localparam logic [2:0] STS_DUPLICATE = 3'd1;
	localparam logic [2:0] STS_FULL      = 3'd2;
	localparam logic [2:0] STS_FOUND     = 3'd3;
	localparam logic [2:0] STS_NOT_FOUND = 3'd4;

	typedef struct packed {
		logic               opcode;
		logic signed [31:0] key_code;
		logic [63:0]        name_low;
		logic [63:0]        name_mid;
		logic [31:0]        name_high;
	} cmd_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [4:0]         entry_count;
		logic signed [31:0] found_key;
		logic [63:0]        found_name_low;
		logic [63:0]        found_name_mid;
		logic [31:0]        found_name_high;
	} result_t;

	// One stored entry as it sits in the entry memory.
	typedef struct packed {
		logic signed [31:0] key_code;
		logic [63:0]        name_low;
		logic [63:0]        name_mid;
		logic [31:0]        name_high;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== design/transpose_self_organizing_set_core.sv =====
// A command scans the entries from the front until a hit or the end of the held set;
// a lookup hit that is not at the front then swaps the entry one place forward.
// Throughput: one command at a time; a new word is accepted in the cycle its
// predecessor's result is strobed. The scan reads each entry, then compares it.
// Reset clears the sequencer and the entry count; the entry memory is not cleared.
// The receiver cannot stall: each result is presented for exactly one cycle.
module transpose_self_organizing_set_core
	import tsos_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  cmd_t    cmd,
	output logic    done,
	output result_t result
);

	// Sequencer states. The scan alternates between issuing a read of entry k
	// and comparing the returned key against the command key with one shared
	// comparator. A lookup hit that is not at the front then passes through
	// S_SWAP_RD and S_SWAP_WR to swap the entry with its predecessor in memory.
	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_READ    = 3'd1;
	localparam logic [2:0] S_CMP     = 3'd2;
	localparam logic [2:0] S_SWAP_RD = 3'd3;
	localparam logic [2:0] S_SWAP_WR = 3'd4;

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_after;
	logic [CNT_W-1:0] k_q;
	logic             done_q;
	cmd_t             cmd_q;
	result_t          res_q, res_d;

	logic             finish;
	logic             res_load;
	logic             k_inc;
	logic             count_inc;
	logic             key_hit;
	logic             set_full;
	logic [CNT_W+4:0] cnt_ext;
	logic [IDX_W-1:0] k_idx;
	logic [IDX_W-1:0] km1_idx;

	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [IDX_W-1:0]   ram_raddr;
	entry_t             ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t             rd;

	tsos_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(ENTRIES)
	) u_entries (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd       = ram_rdata;
	assign k_idx    = k_q[IDX_W-1:0];
	assign km1_idx  = k_idx - IDX_W'(1);
	assign key_hit  = (rd.key_code == cmd_q.key_code);
	assign set_full = (count_q >= CNT_W'(ENTRIES));

	// The count reported is the one held after the operation, cut to the
	// five bits of the result field.
	assign count_after = count_q + CNT_W'(count_inc);
	assign cnt_ext     = {5'b0, count_after};

	always_comb begin
		state_d   = state_q;
		finish    = 1'b0;
		res_load  = 1'b0;
		k_inc     = 1'b0;
		count_inc = 1'b0;
		res_d     = '0;
		ram_we    = 1'b0;
		ram_waddr = k_idx;
		ram_raddr = k_idx;
		ram_wdata = rd;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				if (k_q == count_q) begin
					// Every held entry was compared without a hit.
					finish   = 1'b1;
					res_load = 1'b1;
					state_d  = S_IDLE;
					if (cmd_q.opcode == OP_INSERT) begin
						if (set_full) begin
							res_d.status = STS_FULL;
						end else begin
							res_d.status       = STS_ADDED;
							count_inc          = 1'b1;
							ram_we             = 1'b1;
							ram_waddr          = count_q[IDX_W-1:0];
							ram_wdata.key_code = cmd_q.key_code;
							ram_wdata.name_low = cmd_q.name_low;
							ram_wdata.name_mid = cmd_q.name_mid;
							ram_wdata.name_high = cmd_q.name_high;
						end
					end else begin
						res_d.status = STS_NOT_FOUND;
					end
				end else begin
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				if (key_hit) begin
					res_load = 1'b1;
					if (cmd_q.opcode == OP_INSERT) begin
						res_d.status = STS_DUPLICATE;
						finish       = 1'b1;
						state_d      = S_IDLE;
					end else begin
						res_d.status          = STS_FOUND;
						res_d.found_key       = rd.key_code;
						res_d.found_name_low  = rd.name_low;
						res_d.found_name_mid  = rd.name_mid;
						res_d.found_name_high = rd.name_high;
						if (k_q == '0) begin
							// Hit at the front: nothing moves.
							finish  = 1'b1;
							state_d = S_IDLE;
						end else begin
							state_d = S_SWAP_RD;
						end
					end
				end else begin
					k_inc   = 1'b1;
					state_d = S_READ;
				end
			end
			S_SWAP_RD: begin
				// Fetch the predecessor while the hit entry, kept in the result
				// register, overwrites it; the memory returns the old word.
				ram_raddr           = km1_idx;
				ram_we              = 1'b1;
				ram_waddr           = km1_idx;
				ram_wdata.key_code  = res_q.found_key;
				ram_wdata.name_low  = res_q.found_name_low;
				ram_wdata.name_mid  = res_q.found_name_mid;
				ram_wdata.name_high = res_q.found_name_high;
				state_d             = S_SWAP_WR;
			end
			S_SWAP_WR: begin
				// The old predecessor moves back into the hit slot.
				ram_we    = 1'b1;
				ram_waddr = k_idx;
				ram_wdata = rd;
				finish    = 1'b1;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		res_d.entry_count = cnt_ext[4:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_after;
			done_q  <= finish;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			cmd_q <= cmd;
			k_q   <= '0;
		end else if (k_inc) begin
			k_q <= k_q + CNT_W'(1);
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ENTRIES))
		else $error("entry count exceeds capacity");

	a_count_moves_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> done_q)
		else $error("entry count changed without a result");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && res_q.status != STS_FOUND |->
		res_q.found_key == '0 && res_q.found_name_low == '0 &&
		res_q.found_name_mid == '0 && res_q.found_name_high == '0)
		else $error("found fields not zero on a result without a hit");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not start the sequencer");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy))
		else $error("result strobed without a command in progress");
`endif

endmodule

// ===== design/tsos_ram.sv =====
module tsos_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Read-first: a read of the address being written returns the old word.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== dv/transpose_self_organizing_set_core_test.sv =====
module transpose_self_organizing_set_core_test;
	import tsos_pkg::*;

	// The slowest lookup walks every entry, then swaps.
	// Once the last expected word has come, this many cycles are let pass.
	localparam int DRAIN_CYCLES = 2 * ENTRIES + 8;

	// Worst case per word is a full scan and swap plus the longest gap, for
	// roughly 2030 words; the limit is several times that.
	localparam int CYCLE_LIMIT = 600000;

	localparam int RANDOM_WORDS = 2000;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	cmd_t    cmd;
	logic    done;
	result_t result;

	transpose_self_organizing_set_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	// Mirror of the set contents, kept in the same order as the block keeps it.
	entry_t entry_mirror [ENTRIES];
	int     mirror_count;

	// Result words predicted at acceptance, oldest first.
	result_t pending_results [$];

	int error_count;
	int cycle_count;
	int quiet_run;

	initial begin
		clk = 1'b0;
	end

	always #1 clk = ~clk;

	// Apply one command word to the mirror and return the result word that the
	// block must produce for it.
	function automatic result_t predict_set_op(cmd_t c);
		result_t r;
		entry_t  held;
		bit      hit;
		int      slot;
		r = '0;
		hit = 1'b0;
		slot = 0;
		// The search runs from the front, so the first match wins.
		for (int k = 0; k < mirror_count; k++) begin
			if (!hit && entry_mirror[k].key_code == c.key_code) begin
				hit = 1'b1;
				slot = k;
			end
		end
		if (c.opcode == OP_INSERT) begin
			// A key already held is a duplicate even when the set is full.
			if (hit) begin
				r.status = STS_DUPLICATE;
			end else if (mirror_count >= ENTRIES) begin
				r.status = STS_FULL;
			end else begin
				entry_mirror[mirror_count].key_code = c.key_code;
				entry_mirror[mirror_count].name_low = c.name_low;
				entry_mirror[mirror_count].name_mid = c.name_mid;
				entry_mirror[mirror_count].name_high = c.name_high;
				mirror_count++;
				r.status = STS_ADDED;
			end
		end else begin
			if (hit) begin
				r.status = STS_FOUND;
				r.found_key = entry_mirror[slot].key_code;
				r.found_name_low = entry_mirror[slot].name_low;
				r.found_name_mid = entry_mirror[slot].name_mid;
				r.found_name_high = entry_mirror[slot].name_high;
				// Transpose: the hit moves one place forward unless it is
				// already at the front.
				if (slot != 0) begin
					held = entry_mirror[slot];
					entry_mirror[slot] = entry_mirror[slot - 1];
					entry_mirror[slot - 1] = held;
				end
			end else begin
				r.status = STS_NOT_FOUND;
			end
		end
		// Found fields stay zero on every status other than found.
		r.entry_count = 5'(mirror_count);
		return r;
	endfunction

	function automatic cmd_t make_cmd(logic op, logic signed [31:0] key,
		logic [63:0] lo, logic [63:0] mid, logic [31:0] hi);
		cmd_t c;
		c.opcode = op;
		c.key_code = key;
		c.name_low = lo;
		c.name_mid = mid;
		c.name_high = hi;
		return c;
	endfunction

	function automatic logic [63:0] random_name64();
		return {$urandom, $urandom};
	endfunction

	// A command word with a random name; the name only matters on an insert.
	function automatic cmd_t random_cmd(logic op, logic signed [31:0] key);
		return make_cmd(op, key, random_name64(), random_name64(), $urandom);
	endfunction

	// Key of the entry currently at a random position of the set, or a random key when it is empty.
	function automatic logic signed [31:0] held_key();
		if (mirror_count == 0) begin
			return $urandom;
		end
		return entry_mirror[$urandom_range(mirror_count - 1)].key_code;
	endfunction

	// Called and returning at a falling edge. The gap before the word is drawn
	// here; runs of back-to-back words are mixed in so that start also stays
	// high from one word to the next. Start is left high on return, and it is
	// lowered only by the next gap or by a drain, never within the same step
	// that raises it again.
	task automatic send_word(cmd_t c);
		int gap;
		if (quiet_run > 0) begin
			gap = 0;
			quiet_run--;
		end else begin
			gap = $urandom_range(14);
			if ($urandom_range(15) == 0) begin
				quiet_run = $urandom_range(30, 10);
			end
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		// The word is taken at the first rising edge that sees busy low.
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		pending_results.push_back(predict_set_op(c));
		@(negedge clk);
	endtask

	// Called at a falling edge. Start goes low so that the held word is not
	// taken a second time, then every expected word is awaited.
	task automatic wait_drained();
		start <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// A lookup on the freshly reset, empty set must miss.
	task automatic test_empty_lookup();
		send_word(make_cmd(OP_LOOKUP, 32'sh0000_0000, '0, '0, '0));
	endtask

	// Key and name extremes build a small set; hits at the front and the back,
	// repeated hits that walk an entry forward, a miss and a duplicate.
	task automatic test_small_set();
		send_word(make_cmd(OP_INSERT, 32'sh8000_0000, '0, '0, '0));
		send_word(make_cmd(OP_INSERT, 32'sh7fff_ffff, '1, '1, '1));
		send_word(make_cmd(OP_INSERT, 32'sh0000_0000, '1, '0, '1));
		send_word(make_cmd(OP_INSERT, 32'shffff_ffff, '0, '1, '0));
		send_word(make_cmd(OP_LOOKUP, 32'sh8000_0000, '1, '1, '1));
		send_word(make_cmd(OP_LOOKUP, 32'shffff_ffff, '0, '0, '0));
		send_word(make_cmd(OP_LOOKUP, 32'shffff_ffff, '0, '0, '0));
		send_word(make_cmd(OP_LOOKUP, 32'sh1234_5678, '0, '0, '0));
		send_word(make_cmd(OP_INSERT, 32'sh7fff_ffff, '0, '0, '0));
	endtask

	// Fill up to capacity, then a new key must report full and a held key
	// must still report duplicate.
	task automatic test_fill_and_full();
		while (mirror_count < ENTRIES) begin
			send_word(random_cmd(OP_INSERT, $urandom));
		end
		send_word(random_cmd(OP_INSERT, 32'sh5555_aaaa));
		send_word(random_cmd(OP_INSERT, held_key()));
	endtask

	// Mostly hits on held entries so that the transpose keeps reordering the
	// set, with misses, duplicates and rejected inserts mixed in. Halfway the
	// sender stops until the block has answered everything.
	task automatic test_random_traffic();
		int roll;
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == RANDOM_WORDS / 2) begin
				wait_drained();
			end
			roll = $urandom_range(99);
			if (roll < 60) begin
				send_word(random_cmd(OP_LOOKUP, held_key()));
			end else if (roll < 75) begin
				send_word(random_cmd(OP_LOOKUP, $urandom));
			end else if (roll < 88) begin
				send_word(random_cmd(OP_INSERT, held_key()));
			end else begin
				send_word(random_cmd(OP_INSERT, $urandom));
			end
		end
	endtask

	// Every strobed result word is taken at the rising edge that ends its
	// cycle and compared field by field with the oldest prediction.
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result word with no prediction waiting: status %0d", result.status);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (result.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, result.status);
					error_count++;
				end
				if (result.entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, actual %0d",
						want.entry_count, result.entry_count);
					error_count++;
				end
				if (result.found_key !== want.found_key) begin
					$error("found_key: expected %0d, actual %0d",
						want.found_key, result.found_key);
					error_count++;
				end
				if (result.found_name_low !== want.found_name_low) begin
					$error("found_name_low: expected %h, actual %h",
						want.found_name_low, result.found_name_low);
					error_count++;
				end
				if (result.found_name_mid !== want.found_name_mid) begin
					$error("found_name_mid: expected %h, actual %h",
						want.found_name_mid, result.found_name_mid);
					error_count++;
				end
				if (result.found_name_high !== want.found_name_high) begin
					$error("found_name_high: expected %h, actual %h",
						want.found_name_high, result.found_name_high);
					error_count++;
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		error_count = 0;
		cycle_count = 0;
		quiet_run = 0;
		mirror_count = 0;
		for (int k = 0; k < ENTRIES; k++) begin
			entry_mirror[k] = '0;
		end
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_empty_lookup();
		test_small_set();
		test_fill_and_full();
		test_random_traffic();

		// Let the last word finish, then allow the longest scan to show any
		// stray result word.
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
